// ===== rtl/core/ohc_pkg.sv =====
// Shared types, constants and bit-mapping functions of the odd-parity Hamming codec.
package ohc_pkg;

  // Longest codeword the block handles, in bits.
  localparam int MAX_CODE_BITS = 63;
  // Number of parity groups that fit in a 63-bit word.
  localparam int GROUPS = 6;

  // Operation codes carried on s_tuser.
  localparam logic FUNC_ENCODE = 1'b0;
  localparam logic FUNC_DECODE = 1'b1;

  typedef logic [62:0] word_t;
  typedef logic [5:0]  count_t;
  typedef logic [2:0]  kcount_t;

  // One finished result item.
  typedef struct packed {
    word_t  bits;
    count_t count;
    count_t pos;
    logic   err;
  } result_t;

  // Ones in the lowest n bits.
  function automatic word_t low_mask(count_t n);
    word_t m;
    for (int j = 0; j < 63; j++) begin
      m[j] = (j < int'(n));
    end
    return m;
  endfunction

  function automatic logic is_pow2(int p);
    return (p != 0) && ((p & (p - 1)) == 0);
  endfunction

  // Place data bits, in order, at the positions that are not powers of two.
  function automatic word_t expand(word_t d);
    word_t w;
    int    idx;
    w   = '0;
    idx = 0;
    for (int p = 1; p <= 63; p++) begin
      if (!is_pow2(p)) begin
        w[p-1] = d[idx];
        idx++;
      end
    end
    return w;
  endfunction

  // Gather the bits at positions that are not powers of two into the low bits.
  function automatic word_t compact(word_t w);
    word_t d;
    int    idx;
    d   = '0;
    idx = 0;
    for (int p = 1; p <= 63; p++) begin
      if (!is_pow2(p)) begin
        d[idx] = w[p-1];
        idx++;
      end
    end
    return d;
  endfunction

  // Positions p whose index has bit i set.
  function automatic word_t group_mask(int i);
    word_t g;
    for (int p = 1; p <= 63; p++) begin
      g[p-1] = ((p >> i) & 1) != 0;
    end
    return g;
  endfunction

  // Least K >= 2 with 2^K >= n + K + 1.
  function automatic kcount_t enc_parity_count(count_t n);
    int k;
    k = 7;
    for (int kk = 7; kk >= 2; kk--) begin
      if ((1 << kk) >= int'(n) + kk + 1) begin
        k = kk;
      end
    end
    return kcount_t'(k);
  endfunction

  // Number of powers of two not above n, which is floor(log2 n) + 1 for n >= 1.
  function automatic kcount_t dec_group_count(count_t n);
    int c;
    c = 0;
    for (int i = 0; i < GROUPS; i++) begin
      if ((1 << i) <= int'(n)) begin
        c++;
      end
    end
    return kcount_t'(c);
  endfunction

endpackage

// ===== rtl/core/ohc_encoder.sv =====
// Encoder: expands data bits into a codeword and sets the odd-parity bits.
module ohc_encoder (
  input  ohc_pkg::count_t  bit_count,
  input  ohc_pkg::word_t   bits,
  output ohc_pkg::result_t res
);
  import ohc_pkg::*;

  kcount_t    k;
  logic [6:0] len;
  logic       err;
  word_t      code;

  always_comb begin
    k    = enc_parity_count(bit_count);
    len  = {1'b0, bit_count} + 7'(k);
    err  = (bit_count == '0) || (len > 7'(MAX_CODE_BITS));
    code = expand(bits & low_mask(bit_count));

    // Each parity bit makes its group hold an odd number of ones.
    for (int i = 0; i < GROUPS; i++) begin
      if ((i < int'(k)) && !(^(code & group_mask(i)))) begin
        code[(2**i)-1] = 1'b1;
      end
    end

    // A length error returns zeros.
    if (err) begin
      res = '{bits: '0, count: '0, pos: '0, err: 1'b1};
    end else begin
      res = '{bits: code, count: len[5:0], pos: '0, err: 1'b0};
    end
  end

endmodule

// ===== rtl/core/ohc_decoder.sv =====
// Decoder: computes the syndrome, repairs one bit and compacts the data bits.
module ohc_decoder (
  input  ohc_pkg::count_t  bit_count,
  input  ohc_pkg::word_t   bits,
  output ohc_pkg::result_t res
);
  import ohc_pkg::*;

  kcount_t k;
  word_t   w;
  count_t  syn;
  count_t  flip_idx;
  logic    fix;
  logic    err;

  always_comb begin
    k = dec_group_count(bit_count);
    w = bits & low_mask(bit_count);

    // A group with an even count sets its bit of the syndrome.
    for (int i = 0; i < GROUPS; i++) begin
      syn[i] = (i < int'(k)) && !(^(w & group_mask(i)));
    end

    // A syndrome that points past the word flips nothing.
    fix      = (syn != '0) && (syn <= bit_count);
    flip_idx = syn - 6'd1;
    if (fix) begin
      w[flip_idx] = ~w[flip_idx];
    end

    err = (bit_count == '0) || ({1'b0, bit_count} > 7'(MAX_CODE_BITS));

    if (err) begin
      res = '{bits: '0, count: '0, pos: '0, err: 1'b1};
    end else begin
      res = '{bits: compact(w), count: bit_count - 6'(k),
              pos: (fix ? syn : '0), err: 1'b0};
    end
  end

endmodule

// ===== rtl/core/odd_parity_hamming_codec.sv =====
// Top level of the odd-parity Hamming codec: input register, encode/decode, result register.
//
//  channel | dir | tdata (low bit up)                              | tuser
//  s_      | in  | bit_count[5:0], bits[68:6], zero pad [71:69]    | func
//  m_      | out | result_bits[62:0], result_count[68:63],         | length_error
//          |     | corrected_position[74:69], zero pad [79:75]     |
//
// Each item passes through the input register and then the result register;
// one item is taken every cycle while m_tready stays high.
// The parity trees and bit maps sit between these two register stages.
// rst empties both stages; payload registers are not reset.
// A stall on m_tready holds the result and lets the input register fill, then s_tready drops.
module odd_parity_hamming_codec (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [71:0] s_tdata,   // bit_count, bits, zero pad
  input  logic        s_tuser,   // func
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [79:0] m_tdata,   // result_bits, result_count, corrected_position, zero pad
  output logic        m_tuser    // length_error
);
  import ohc_pkg::*;

  // Input register.
  logic    in_valid;
  logic    in_func;
  count_t  in_count;
  word_t   in_bits;

  // Result register.
  logic    out_valid;
  result_t out_res;

  result_t enc_res;
  result_t dec_res;
  logic    out_load;

  // The result register takes a new item when it is empty or being drained.
  assign out_load = !out_valid || m_tready;
  assign s_tready = !in_valid || out_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_func  <= s_tuser;
      in_count <= s_tdata[5:0];
      in_bits  <= s_tdata[68:6];
    end
  end

  ohc_encoder u_enc (
    .bit_count (in_count),
    .bits      (in_bits),
    .res       (enc_res)
  );

  ohc_decoder u_dec (
    .bit_count (in_count),
    .bits      (in_bits),
    .res       (dec_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= in_valid;
    end
  end

  // Pick the operation's result into the result register.
  always_ff @(posedge clk) begin
    if (out_load && in_valid) begin
      out_res <= (in_func == FUNC_DECODE) ? dec_res : enc_res;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {5'd0, out_res.pos, out_res.count, out_res.bits};
  assign m_tuser  = out_res.err;

endmodule

// ===== tb/odd_parity_hamming_codec_tb.sv =====
// Self-checking testbench of the odd-parity Hamming codec: directed, random and flow-control tests.
module odd_parity_hamming_codec_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ohc_pkg::*;

  localparam int QUIET_LIMIT = 4000;  // cycles with no item moving on either side
  localparam int HOLD_CYCLES = 200;   // long receiver hold-off
  localparam int TAIL_CYCLES = 8;     // two register stages plus margin
  localparam int MAX_REPORTS = 10;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [71:0] s_tdata  = '0;   // bit_count, bits, zero pad
  logic        s_tuser  = 1'b0; // func
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [79:0] m_tdata;         // result_bits, result_count, corrected_position, zero pad
  logic        m_tuser;         // length_error

  // Expected results in the order their items were taken.
  result_t pending_results[$];
  int      mismatch_count = 0;

  // Flow control knobs shared by the test tasks and the receiver.
  bit src_gaps    = 1'b1;
  bit sink_stalls = 1'b1;
  int hold_token  = 0;

  odd_parity_hamming_codec dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always #5 clk = ~clk;

  // Mostly no gap, often a short one, rarely a long one.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic word_t rand_word();
    return word_t'({$urandom(), $urandom()});
  endfunction

  // Computes the codec result for one item: encode places data and sets odd
  // parity per group, decode forms the syndrome, repairs and compacts.
  function automatic result_t hamming_result(logic op, count_t n, word_t raw);
    result_t r;
    word_t   w;
    int      k, len, idx, syn, m;
    logic    par;
    r = '0;
    w = '0;
    for (int j = 0; j < int'(n); j++) w[j] = raw[j];
    if (op == FUNC_ENCODE) begin
      k = 2;
      while ((1 << k) < int'(n) + k + 1) k++;
      len = int'(n) + k;
      if (n == 0 || len > MAX_CODE_BITS) begin
        r.err = 1'b1;
      end else begin
        // Data goes to every position that is not a power of two.
        idx = 0;
        for (int p = 1; p <= len; p++) begin
          if ((p & (p - 1)) != 0) begin
            r.bits[p-1] = w[idx];
            idx++;
          end
        end
        // Each parity bit makes its group hold an odd number of ones.
        for (int i = 0; i < k; i++) begin
          m   = 1 << i;
          par = 1'b0;
          for (int p = 1; p <= len; p++) begin
            if ((p & m) != 0) par ^= r.bits[p-1];
          end
          if (!par) r.bits[m-1] = 1'b1;
        end
        r.count = count_t'(len);
      end
    end else if (n == 0) begin
      r.err = 1'b1;
    end else begin
      // A group with an even count sets its bit in the syndrome.
      syn = 0;
      for (int i = 0; (1 << i) <= int'(n); i++) begin
        m   = 1 << i;
        par = 1'b0;
        for (int p = 1; p <= int'(n); p++) begin
          if ((p & m) != 0) par ^= w[p-1];
        end
        if (!par) syn |= m;
      end
      // A syndrome past the end of the word repairs nothing.
      if (syn != 0 && syn <= int'(n)) begin
        w[syn-1] = ~w[syn-1];
        r.pos    = count_t'(syn);
      end
      idx = 0;
      for (int p = 1; p <= int'(n); p++) begin
        if ((p & (p - 1)) != 0) begin
          r.bits[idx] = w[p-1];
          idx++;
        end
      end
      r.count = count_t'(idx);
    end
    return r;
  endfunction

  // Offers one item, waits for it to be taken and records its expected result.
  task automatic send_item(input logic op, input count_t n, input word_t bits);
    int gap;
    gap = src_gaps ? gap_len() : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {3'b000, bits, n};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pending_results.push_back(hamming_result(op, n, bits));
  endtask

  // Drops valid and waits for the clock so the next item starts on a fresh step.
  task automatic release_source();
    s_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_drain();
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Mostly well-formed traffic: valid encodes and codewords with zero, one
  // or two flipped bits, plus some raw items of any length.
  task automatic send_random_item();
    int      sel, flip, at;
    word_t   cw;
    result_t enc;
    sel = $urandom_range(0, 99);
    if (sel < 40) begin
      send_item(FUNC_ENCODE, count_t'($urandom_range(1, 57)), rand_word());
    end else if (sel < 80) begin
      enc  = hamming_result(FUNC_ENCODE, count_t'($urandom_range(1, 57)), rand_word());
      cw   = enc.bits | (rand_word() & ~((word_t'(1) << enc.count) - word_t'(1)));
      flip = $urandom_range(0, 99);
      if (flip >= 30) begin
        at     = $urandom_range(0, int'(enc.count) - 1);
        cw[at] = ~cw[at];
      end
      if (flip >= 85) begin
        at     = $urandom_range(0, int'(enc.count) - 1);
        cw[at] = ~cw[at];
      end
      send_item(FUNC_DECODE, enc.count, cw);
    end else begin
      send_item(logic'($urandom_range(0, 1)), count_t'($urandom_range(0, 63)), rand_word());
    end
  endtask

  // Encode corners: shortest and longest words, lengths just out of range,
  // and junk above the length.
  task automatic test_encode_corners();
    src_gaps    = 1'b1;
    sink_stalls = 1'b1;
    send_item(FUNC_ENCODE, 6'd1, '0);
    send_item(FUNC_ENCODE, 6'd1, '1);
    send_item(FUNC_ENCODE, 6'd2, 63'b10);
    send_item(FUNC_ENCODE, 6'd4, {59'h5a5a5a5a5a5a5a5, 4'b1011});
    send_item(FUNC_ENCODE, 6'd11, rand_word());
    send_item(FUNC_ENCODE, 6'd26, rand_word());
    send_item(FUNC_ENCODE, 6'd57, '1);
    send_item(FUNC_ENCODE, 6'd57, '0);
    send_item(FUNC_ENCODE, 6'd58, rand_word());
    send_item(FUNC_ENCODE, 6'd63, '1);
    send_item(FUNC_ENCODE, 6'd0, '1);
    release_source();
  endtask

  // Decode corners: zero length, tiny words, a syndrome past the end,
  // full-length words and single-bit repairs at low and top positions.
  task automatic test_decode_corners();
    result_t enc;
    word_t   cw;
    send_item(FUNC_DECODE, 6'd0, '1);
    send_item(FUNC_DECODE, 6'd1, 63'b1);
    send_item(FUNC_DECODE, 6'd1, '0);
    send_item(FUNC_DECODE, 6'd2, 63'b11);
    send_item(FUNC_DECODE, 6'd3, 63'b111);
    send_item(FUNC_DECODE, 6'd5, {58'h2aaaaaaaaaaaaaa, 5'b00000});
    enc   = hamming_result(FUNC_ENCODE, 6'd4, 63'b1010);
    cw    = enc.bits;
    cw[2] = ~cw[2];
    send_item(FUNC_DECODE, enc.count, cw);
    send_item(FUNC_DECODE, 6'd63, '1);
    send_item(FUNC_DECODE, 6'd63, '0);
    enc    = hamming_result(FUNC_ENCODE, 6'd57, '1);
    cw     = enc.bits;
    cw[62] = ~cw[62];
    send_item(FUNC_DECODE, enc.count, cw);
    send_item(FUNC_DECODE, 6'd32, rand_word());
    release_source();
  endtask

  task automatic test_random_traffic(input int items);
    src_gaps    = 1'b1;
    sink_stalls = 1'b1;
    repeat (items) send_random_item();
    release_source();
  endtask

  // Back-to-back items with the receiver always ready.
  task automatic test_full_rate(input int items);
    src_gaps    = 1'b0;
    sink_stalls = 1'b0;
    repeat (items) send_random_item();
    release_source();
  endtask

  // The receiver holds off while items keep coming, so the input side stalls.
  task automatic test_output_hold(input int items);
    src_gaps    = 1'b0;
    sink_stalls = 1'b0;
    hold_token++;
    repeat (items) send_random_item();
    release_source();
  endtask

  // The sender stops until every result is out, then resumes.
  task automatic test_drain_pause(input int items);
    src_gaps    = 1'b1;
    sink_stalls = 1'b1;
    repeat (items) send_random_item();
    release_source();
    wait_drain();
    repeat (items) send_random_item();
    release_source();
  endtask

  // Receiver: random stalls, plus a long hold-off whenever a test asks for one.
  always @(posedge clk) begin : drive_ready
    int g;
    int hold_seen;
    int hold_left;
    int stall_left;
    if (hold_seen != hold_token) begin
      hold_seen = hold_token;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      m_tready <= 1'b0;
    end else if (sink_stalls) begin
      g = gap_len();
      if (g > 0) begin
        stall_left = g - 1;
        m_tready   <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Compares each result item with the oldest expectation.
  always @(posedge clk) begin : check_results
    result_t want;
    result_t got;
    if (!rst && m_tvalid && m_tready) begin
      got.bits  = m_tdata[62:0];
      got.count = m_tdata[68:63];
      got.pos   = m_tdata[74:69];
      got.err   = m_tuser;
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("mismatch: result with nothing expected, bits %h count %0d",
                   got.bits, got.count);
      end else begin
        want = pending_results.pop_front();
        if (got.bits !== want.bits || got.count !== want.count ||
            got.pos !== want.pos || got.err !== want.err) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display({"mismatch: expected bits %h count %0d pos %0d err %b, ",
                      "got bits %h count %0d pos %0d err %b"},
                     want.bits, want.count, want.pos, want.err,
                     got.bits, got.count, got.pos, got.err);
        end
      end
    end
  end

  // Ends the run if no item moves on either side for too long.
  always @(posedge clk) begin : watchdog
    int quiet;
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet = 0;
    end else begin
      quiet++;
    end
    if (quiet >= QUIET_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_encode_corners();
    test_decode_corners();
    test_random_traffic(1230);
    test_full_rate(300);
    test_output_hold(80);
    test_drain_pause(60);
    wait_drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/ohc_pkg.sv
rtl/core/ohc_encoder.sv
rtl/core/ohc_decoder.sv
rtl/core/odd_parity_hamming_codec.sv
tb/odd_parity_hamming_codec_tb.sv
